// ----- design/cds_pkg.sv -----
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types and constants for the coverage depth segmenter.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int unsigned MAX_DEPTH = 1000000;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned CONTIG_W = 16;
    localparam int unsigned POS_W    = 31;
    localparam int unsigned DEPTH_W  = 20;
    localparam int unsigned QUAL_W   = 8;
    localparam int unsigned TOL_W    = 17;
    localparam int unsigned BAND_W   = 21;
    localparam int unsigned LEN_W    = 31;
    localparam int unsigned SUM_W    = 52;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [TOL_W-1:0] ONE_Q16   = TOL_W'(65536);
    localparam logic [15:0]      ROUND_Q16 = 16'd32702;

    localparam logic [QUAL_W-1:0] QUAL_THR_RESET  = QUAL_W'(20);
    localparam logic [TOL_W-1:0]  DEPTH_TOL_RESET = TOL_W'(13107);

    typedef enum logic [OP_W-1:0] {
        OP_HEADER = 2'd0,
        OP_READ   = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef enum logic {
        REG_QUAL_THR  = 1'b0,
        REG_DEPTH_TOL = 1'b1
    } t_reg;

endpackage

// ----- design/coverage_depth_segmenter.sv -----
// ----------------------------------------------------------------------------
// coverage_depth_segmenter
// Splits a pileup stream into runs of similar coverage depth.
// ----------------------------------------------------------------------------
// Takes one item per clock. Each item updates the run state in the cycle it is
// accepted. A closed run is loaded into the result register at that same edge
// and shows on the result port from the next cycle.
// The input side is ready whenever the result register is empty or its beat
// is being taken in the same cycle, so a full result register stalls input
// only while the downstream side holds off. The depth band of a run is worked
// out by a 20x17 and a 20x18 multiply when the run opens; all other work is
// compares and saturating adds on the run counters.
module coverage_depth_segmenter
    import cds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,

    // input items
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [CONTIG_W-1:0] i_contig_id,
    input  logic [POS_W-1:0]    i_position,
    input  logic [DEPTH_W-1:0]  i_depth,
    input  logic [QUAL_W-1:0]   i_read_quality,

    // closed runs
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [CONTIG_W-1:0] o_segment_contig,
    output logic [POS_W-1:0]    o_segment_start,
    output logic [LEN_W-1:0]    o_segment_length,
    output logic [SUM_W-1:0]    o_depth_sum,
    output logic [SUM_W-1:0]    o_high_quality_sum
);

    // configuration registers
    logic [QUAL_W-1:0]   r_qual_thr;
    logic [TOL_W-1:0]    r_depth_tol;

    // run state
    logic                r_run_open,    n_run_open;
    logic [CONTIG_W-1:0] r_prev_contig, n_prev_contig;
    logic [POS_W-1:0]    r_prev_pos,    n_prev_pos;
    logic [BAND_W-1:0]   r_band_low,    n_band_low;
    logic [BAND_W-1:0]   r_band_high,   n_band_high;
    logic [POS_W-1:0]    r_run_start,   n_run_start;
    logic [LEN_W-1:0]    r_run_len,     n_run_len;
    logic [SUM_W-1:0]    r_depth_sum,   n_depth_sum;
    logic [SUM_W-1:0]    r_high_sum,    n_high_sum;

    // result register
    logic                r_out_valid;
    logic [CONTIG_W-1:0] r_out_contig;
    logic [POS_W-1:0]    r_out_start;
    logic [LEN_W-1:0]    r_out_len;
    logic [SUM_W-1:0]    r_out_depth_sum;
    logic [SUM_W-1:0]    r_out_high_sum;

    logic                w_in_fire;
    logic                w_emit;
    logic                w_cfg_wr;
    logic [DEPTH_W-1:0]  w_depth_cap;
    logic [TOL_W-1:0]    w_low_factor;
    logic [TOL_W:0]      w_high_factor;
    logic [36:0]         w_lo_prod;
    logic [37:0]         w_hi_prod;
    logic [BAND_W-1:0]   w_lo_band;
    logic [BAND_W:0]     w_hi_shift;
    logic [BAND_W-1:0]   w_hi_band;
    logic [POS_W:0]      w_next_pos;
    logic                w_break;
    logic [SUM_W:0]      w_sum_add;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qual_thr  <= QUAL_THR_RESET;
            r_depth_tol <= DEPTH_TOL_RESET;
        end else if (w_cfg_wr) begin
            unique case (t_reg'(paddr[2]))
                REG_QUAL_THR:  r_qual_thr  <= pwdata[QUAL_W-1:0];
                REG_DEPTH_TOL: r_depth_tol <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[2]))
            REG_QUAL_THR:  prdata = APB_DW'(r_qual_thr);
            REG_DEPTH_TOL: prdata = APB_DW'(r_depth_tol);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // header datapath
    // ------------------------------------------------------------------------
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_depth_cap = (i_depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : i_depth;

    // tolerance above one clamps the lower factor to zero
    assign w_low_factor  = (r_depth_tol > ONE_Q16) ? '0 : ONE_Q16 - r_depth_tol;
    assign w_high_factor = {1'b0, ONE_Q16} + {1'b0, r_depth_tol};

    assign w_lo_prod = 37'(w_depth_cap) * 37'(w_low_factor) + 37'(ROUND_Q16);
    assign w_hi_prod = 38'(w_depth_cap) * 38'(w_high_factor) + 38'(ROUND_Q16);

    // low band never exceeds the depth itself, so 21 bits always hold it
    assign w_lo_band  = w_lo_prod[16 +: BAND_W];
    assign w_hi_shift = w_hi_prod[16 +: BAND_W+1];
    assign w_hi_band  = w_hi_shift[BAND_W] ? '1 : w_hi_shift[BAND_W-1:0];

    // 32-bit compare, so the last position is never followed
    assign w_next_pos = {1'b0, r_prev_pos} + (POS_W+1)'(1);

    assign w_break = !r_run_open
                  || (i_contig_id != r_prev_contig)
                  || ({1'b0, i_position} != w_next_pos)
                  || (BAND_W'(w_depth_cap) < r_band_low)
                  || (BAND_W'(w_depth_cap) > r_band_high);

    assign w_sum_add = {1'b0, r_depth_sum} + (SUM_W+1)'(w_depth_cap);

    always_comb begin
        n_run_open    = r_run_open;
        n_prev_contig = r_prev_contig;
        n_prev_pos    = r_prev_pos;
        n_band_low    = r_band_low;
        n_band_high   = r_band_high;
        n_run_start   = r_run_start;
        n_run_len     = r_run_len;
        n_depth_sum   = r_depth_sum;
        n_high_sum    = r_high_sum;
        w_emit        = 1'b0;

        if (w_in_fire) begin
            case (t_op'(i_op))
                OP_HEADER: begin
                    if (w_break) begin
                        w_emit        = r_run_open;
                        n_run_open    = 1'b1;
                        n_prev_contig = i_contig_id;
                        n_run_start   = i_position;
                        n_band_low    = w_lo_band;
                        n_band_high   = w_hi_band;
                        n_run_len     = LEN_W'(1);
                        n_depth_sum   = SUM_W'(w_depth_cap);
                        n_high_sum    = '0;
                    end else begin
                        if (r_run_len != '1) begin
                            n_run_len = r_run_len + LEN_W'(1);
                        end
                        n_depth_sum = w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
                    end
                    n_prev_pos = i_position;
                end
                OP_READ: begin
                    if (r_run_open && (i_read_quality >= r_qual_thr)
                            && (r_high_sum != '1)) begin
                        n_high_sum = r_high_sum + SUM_W'(1);
                    end
                end
                OP_FLUSH: begin
                    if (r_run_open) begin
                        w_emit      = 1'b1;
                        n_run_open  = 1'b0;
                        n_run_len   = '0;
                        n_depth_sum = '0;
                        n_high_sum  = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open <= 1'b0;
        end else begin
            r_run_open <= n_run_open;
        end
    end

    // run payload only matters while a run is open
    always_ff @(posedge i_clk) begin
        r_prev_contig <= n_prev_contig;
        r_prev_pos    <= n_prev_pos;
        r_band_low    <= n_band_low;
        r_band_high   <= n_band_high;
        r_run_start   <= n_run_start;
        r_run_len     <= n_run_len;
        r_depth_sum   <= n_depth_sum;
        r_high_sum    <= n_high_sum;
    end

    // ------------------------------------------------------------------------
    // result register: holds the closed run as it stood before this beat
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_contig    <= r_prev_contig;
            r_out_start     <= r_run_start;
            r_out_len       <= r_run_len;
            r_out_depth_sum <= r_depth_sum;
            r_out_high_sum  <= r_high_sum;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_segment_contig   = r_out_contig;
    assign o_segment_start    = r_out_start;
    assign o_segment_length   = r_out_len;
    assign o_depth_sum        = r_out_depth_sum;
    assign o_high_quality_sum = r_out_high_sum;

endmodule

// ----- bench/tb_coverage_depth_segmenter.sv -----
// ----------------------------------------------------------------------------
// tb_coverage_depth_segmenter
// Self-checking bench for the coverage depth segmenter.
// ----------------------------------------------------------------------------
// Drives pileup headers, read qualities and flushes through the input channel
// and predicts every closed run from a local model of the run state. Results
// are checked field by field in order. The threshold and tolerance registers
// are written over APB between phases while the block is idle. The phases
// cycle through four mixes of sender gaps and receiver stalls, and one phase
// includes a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_coverage_depth_segmenter;
    import cds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0]  OP_SPARE = 2'd3;
    localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
    localparam int unsigned      N_PHASES = 8;
    localparam int unsigned      PHASE_ITEMS = 250;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [CONTIG_W-1:0] contig;
        logic [POS_W-1:0]    position;
        logic [DEPTH_W-1:0]  depth;
        logic [QUAL_W-1:0]   qual;
    } t_item;

    typedef struct packed {
        logic [CONTIG_W-1:0] contig;
        logic [POS_W-1:0]    start;
        logic [LEN_W-1:0]    length;
        logic [SUM_W-1:0]    depth_sum;
        logic [SUM_W-1:0]    high_sum;
    } t_segment;

    // Tracks the open run and queues the runs it closes.
    class segment_checker;
        logic [QUAL_W-1:0]   qual_thr;
        logic [TOL_W-1:0]    depth_tol;
        bit                  run_open;
        logic [CONTIG_W-1:0] run_contig;
        logic [POS_W-1:0]    prev_pos;
        logic [BAND_W-1:0]   band_lo;
        logic [BAND_W-1:0]   band_hi;
        logic [POS_W-1:0]    run_start;
        logic [LEN_W-1:0]    run_len;
        logic [SUM_W-1:0]    run_dsum;
        logic [SUM_W-1:0]    run_hsum;
        t_segment            closed_runs[$];
        int unsigned         items_seen;
        int unsigned         runs_checked;
        int unsigned         errors;

        function new();
            qual_thr     = QUAL_THR_RESET;
            depth_tol    = DEPTH_TOL_RESET;
            run_open     = 1'b0;
            run_contig   = '0;
            prev_pos     = '0;
            band_lo      = '0;
            band_hi      = '0;
            run_start    = '0;
            run_len      = '0;
            run_dsum     = '0;
            run_hsum     = '0;
            items_seen   = 0;
            runs_checked = 0;
            errors       = 0;
        endfunction

        function void set_config(t_reg idx, logic [APB_DW-1:0] val);
            if (idx == REG_QUAL_THR)
                qual_thr = val[QUAL_W-1:0];
            else
                depth_tol = val[TOL_W-1:0];
        endfunction

        function logic [BAND_W-1:0] band_edge(logic [DEPTH_W-1:0] d, logic [63:0] factor);
            logic [63:0] scaled;
            scaled = (64'(d) * factor + 64'(ROUND_Q16)) >> 16;
            return (scaled > 64'({BAND_W{1'b1}})) ? {BAND_W{1'b1}} : scaled[BAND_W-1:0];
        endfunction

        function void close_run();
            closed_runs.push_back(t_segment'{run_contig, run_start, run_len,
                                             run_dsum, run_hsum});
        endfunction

        function void note_item(t_item it);
            logic [DEPTH_W-1:0] d;
            logic [SUM_W:0]     dsum;
            bit                 breaks;
            items_seen++;
            if (it.op == OP_HEADER) begin
                d = (it.depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : it.depth;
                // last position on a contig never has a contiguous successor
                breaks = !run_open || it.contig != run_contig ||
                         32'(it.position) != 32'(prev_pos) + 32'd1 ||
                         d < band_lo || d > band_hi;
                if (breaks) begin
                    if (run_open)
                        close_run();
                    // tolerance above one clamps the lower factor to zero
                    band_lo = band_edge(d, (depth_tol > ONE_Q16) ? 64'd0 :
                                           64'(ONE_Q16 - depth_tol));
                    band_hi = band_edge(d, 64'(ONE_Q16) + 64'(depth_tol));
                    run_open   = 1'b1;
                    run_contig = it.contig;
                    run_start  = it.position;
                    run_len    = '0;
                    run_dsum   = '0;
                    run_hsum   = '0;
                end
                if (run_len != {LEN_W{1'b1}})
                    run_len++;
                dsum = {1'b0, run_dsum} + (SUM_W+1)'(d);
                run_dsum = dsum[SUM_W] ? {SUM_W{1'b1}} : dsum[SUM_W-1:0];
                prev_pos = it.position;
            end else if (it.op == OP_READ) begin
                if (run_open && it.qual >= qual_thr && run_hsum != {SUM_W{1'b1}})
                    run_hsum++;
            end else if (it.op == OP_FLUSH) begin
                if (run_open) begin
                    close_run();
                    run_open = 1'b0;
                    run_len  = '0;
                    run_dsum = '0;
                    run_hsum = '0;
                end
            end
        endfunction

        function void report(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void check_segment(t_segment got);
            t_segment want;
            if (closed_runs.size() == 0) begin
                report("run count (unexpected run, start shown)", 64'd0, 64'(got.start));
                return;
            end
            want = closed_runs.pop_front();
            runs_checked++;
            if (got.contig != want.contig)
                report("segment_contig", 64'(want.contig), 64'(got.contig));
            if (got.start != want.start)
                report("segment_start", 64'(want.start), 64'(got.start));
            if (got.length != want.length)
                report("segment_length", 64'(want.length), 64'(got.length));
            if (got.depth_sum != want.depth_sum)
                report("depth_sum", 64'(want.depth_sum), 64'(got.depth_sum));
            if (got.high_sum != want.high_sum)
                report("high_quality_sum", 64'(want.high_sum), 64'(got.high_sum));
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [APB_AW-1:0]   paddr          = '0;
    logic [APB_DW-1:0]   pwdata         = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                i_in_valid     = 1'b0;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_op           = '0;
    logic [CONTIG_W-1:0] i_contig_id    = '0;
    logic [POS_W-1:0]    i_position     = '0;
    logic [DEPTH_W-1:0]  i_depth        = '0;
    logic [QUAL_W-1:0]   i_read_quality = '0;
    logic                o_out_valid;
    logic                i_out_ready    = 1'b0;
    logic [CONTIG_W-1:0] o_segment_contig;
    logic [POS_W-1:0]    o_segment_start;
    logic [LEN_W-1:0]    o_segment_length;
    logic [SUM_W-1:0]    o_depth_sum;
    logic [SUM_W-1:0]    o_high_quality_sum;

    segment_checker      board = new();
    int unsigned         snd_idle_pct    = 0;
    int unsigned         rcv_stall_pct   = 0;
    int unsigned         hold_off_cycles = 0;

    // generator state for well-formed pileup walks
    logic [CONTIG_W-1:0] gen_contig = '0;
    logic [POS_W-1:0]    gen_pos    = '0;
    int unsigned         gen_depth  = 30;

    coverage_depth_segmenter uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_contig_id        (i_contig_id),
        .i_position         (i_position),
        .i_depth            (i_depth),
        .i_read_quality     (i_read_quality),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_segment_contig   (o_segment_contig),
        .o_segment_start    (o_segment_start),
        .o_segment_length   (o_segment_length),
        .o_depth_sum        (o_depth_sum),
        .o_high_quality_sum (o_high_quality_sum)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timed out waiting for the segmenter");
        $display("FAILURE");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_ready <= 1'b0;
                for (int n = 0; n < hold_off_cycles; n++)
                    @(negedge i_clk);
                hold_off_cycles = 0;
            end
            i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_segment(t_segment'{o_segment_contig, o_segment_start,
                                           o_segment_length, o_depth_sum,
                                           o_high_quality_sum});
    end

    function automatic t_item pileup_item(logic [OP_W-1:0] op, logic [CONTIG_W-1:0] contig,
                                          logic [POS_W-1:0] position,
                                          logic [DEPTH_W-1:0] depth,
                                          logic [QUAL_W-1:0] qual);
        return t_item'{op, contig, position, depth, qual};
    endfunction

    function automatic void pick_depth();
        case ($urandom_range(9))
            0:       gen_depth = $urandom_range(20'hFFFFF);
            1:       gen_depth = MAX_DEPTH - $urandom_range(2000);
            2:       gen_depth = $urandom_range(3);
            default: gen_depth = $urandom_range(300);
        endcase
    endfunction

    // Mostly contiguous walks with jittered depth; junk in unused fields.
    function automatic t_item next_item();
        t_item       it;
        int unsigned roll;
        int unsigned spread;
        int unsigned dv;
        it.contig   = CONTIG_W'($urandom);
        it.position = POS_W'($urandom);
        it.depth    = DEPTH_W'($urandom);
        it.qual     = QUAL_W'($urandom);
        roll = $urandom_range(999);
        if (roll < 15) begin
            it.op = OP_FLUSH;
        end else if (roll < 25) begin
            it.op = OP_SPARE;
        end else if (roll < 330) begin
            it.op = OP_READ;
        end else begin
            it.op = OP_HEADER;
            roll = $urandom_range(99);
            if (roll < 4) begin
                gen_contig = CONTIG_W'($urandom);
                gen_pos = ($urandom_range(3) == 0) ? POS_MAX - POS_W'($urandom_range(3))
                                                   : POS_W'($urandom);
            end else if (roll < 8) begin
                gen_pos = POS_W'($urandom);
            end else if (roll < 12) begin
                pick_depth();
                gen_pos = gen_pos + 1'b1;
            end else begin
                gen_pos = gen_pos + 1'b1;
            end
            spread = gen_depth / 8;
            dv = gen_depth + $urandom_range(spread) - spread / 2;
            if (dv > 20'hFFFFF)
                dv = 20'hFFFFF;
            it.contig   = gen_contig;
            it.position = gen_pos;
            it.depth    = DEPTH_W'(dv);
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_item(t_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= it.op;
        i_contig_id    <= it.contig;
        i_position     <= it.position;
        i_depth        <= it.depth;
        i_read_quality <= it.qual;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_config(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (board.closed_runs.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        logic [APB_DW-1:0] thr_val;
        logic [APB_DW-1:0] tol_val;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset settings: threshold 20, tolerance 0.2
        send_item(pileup_item(OP_FLUSH, 0, 0, 0, 0));          // nothing open
        send_item(pileup_item(OP_READ, 0, 0, 0, 255));         // nothing open
        send_item(pileup_item(OP_SPARE, 16'hFFFF, POS_MAX, 20'hFFFFF, 8'hFF));
        send_item(pileup_item(OP_HEADER, 0, 0, 0, 0));
        send_item(pileup_item(OP_HEADER, 0, 1, 0, 0));
        send_item(pileup_item(OP_READ, 0, 0, 0, 19));
        send_item(pileup_item(OP_READ, 0, 0, 0, 20));
        send_item(pileup_item(OP_READ, 0, 0, 0, 0));
        send_item(pileup_item(OP_READ, 0, 0, 0, 255));
        send_item(pileup_item(OP_HEADER, 0, 2, 1, 0));         // above a zero band
        send_item(pileup_item(OP_HEADER, 0, 3, 1, 0));
        send_item(pileup_item(OP_HEADER, 16'hFFFF, POS_MAX - 1'b1, 20'hFFFFF, 0)); // capped
        send_item(pileup_item(OP_HEADER, 16'hFFFF, POS_MAX, DEPTH_W'(MAX_DEPTH), 0));
        send_item(pileup_item(OP_HEADER, 16'hFFFF, 0, DEPTH_W'(MAX_DEPTH), 0)); // no wrap
        send_item(pileup_item(OP_HEADER, 16'hFFFF, 1, 20'd800000, 0));  // below band
        send_item(pileup_item(OP_HEADER, 16'hFFFF, 2, DEPTH_W'(MAX_DEPTH), 0)); // above band
        send_item(pileup_item(OP_HEADER, 16'hFFFE, 3, DEPTH_W'(MAX_DEPTH), 0)); // new contig
        send_item(pileup_item(OP_HEADER, 16'hFFFE, 5, DEPTH_W'(MAX_DEPTH), 0)); // gap
        send_item(pileup_item(OP_READ, 0, 0, 0, 100));
        send_item(pileup_item(OP_FLUSH, 0, 0, 0, 0));
        send_item(pileup_item(OP_FLUSH, 0, 0, 0, 0));
        send_item(pileup_item(OP_READ, 0, 0, 0, 200));
        send_item(pileup_item(OP_HEADER, 16'h5AA5, 31'h2AAA_5555, 20'hAAAAA, 0));
        send_item(pileup_item(OP_FLUSH, 0, 0, 0, 0));
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(negedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            case (p % 4)
                0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin snd_idle_pct = 61; rcv_stall_pct = 0;  end
                2:       begin snd_idle_pct = 0;  rcv_stall_pct = 61; end
                default: begin snd_idle_pct = 26; rcv_stall_pct = 26; end
            endcase
            if (p > 0) begin
                case (p)
                    1:       begin thr_val = 0;   tol_val = 0;     end
                    2:       begin thr_val = 255; tol_val = 65536; end
                    3:       begin thr_val = $urandom_range(255); tol_val = 32'h1FFFF; end
                    6:       begin thr_val = $urandom; tol_val = $urandom_range(3000); end
                    default: begin thr_val = $urandom; tol_val = $urandom; end
                endcase
                write_reg(REG_QUAL_THR, thr_val);
                write_reg(REG_DEPTH_TOL, tol_val);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 60)
                    hold_off_cycles = 300;   // sender keeps offering meanwhile
                if (p == 5 && n == PHASE_ITEMS / 2) begin
                    i_in_valid <= 1'b0;
                    @(negedge i_clk);
                    wait_drained();
                end
                send_item(next_item());
            end
            i_in_valid <= 1'b0;
            wait_drained();
            repeat (4) @(negedge i_clk);
        end

        wait_drained();
        repeat (8) @(negedge i_clk);
        $display("Covered %0d input beats over %0d threshold/tolerance settings and idle mixes,",
                 board.items_seen, N_PHASES);
        $display("checked %0d closed runs, %0d mismatches", board.runs_checked, board.errors);
        if (board.errors == 0 && board.closed_runs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- coverage_depth_segmenter.f -----
design/cds_pkg.sv
design/coverage_depth_segmenter.sv
bench/tb_coverage_depth_segmenter.sv
